// File: rtl/mdm_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum drive mixer package
// Field widths, lane counts and the elaboration-time cosine generator shared
// by the mixer modules.
// ----------------------------------------------------------------------------
package mdm_pkg;

  // Field widths of the command and power words.
  localparam int unsigned HeadingW  = 9;
  localparam int unsigned CmdW      = 16;
  localparam int unsigned PowerW    = 8;
  localparam int unsigned MaxPowerW = 7;
  localparam int unsigned QuotW     = 7;
  localparam int unsigned NumWheels = 4;

  // Wheel lane order.
  localparam int unsigned WheelFl = 0;
  localparam int unsigned WheelBl = 1;
  localparam int unsigned WheelFr = 2;
  localparam int unsigned WheelBr = 3;

  localparam logic [MaxPowerW-1:0] MaxPowerReset = 7'd100;

  // Pi with 60 fraction bits, and one degree in radians in the same format.
  localparam longint unsigned PiQ60  = 64'h3243F6A8885A308D;
  localparam longint unsigned DegQ60 = PiQ60 / 64'd180;
  localparam int unsigned     SeriesTerms = 10;

  // Product of two Q60 values below 2^61, truncated to Q60.
  function automatic longint unsigned mul_q60(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ((ah * bh) << 4) + (mid >> 28);
  endfunction

  // Truncating quotient by long division, for the small series divisors.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series for cosine or sine of d degrees (0 to 45) in Q60.
  function automatic longint unsigned trig_q60(input int unsigned d, input bit want_sin);
    longint unsigned x, x2, term, sum, dv;
    x    = longint'(d) * DegQ60;
    x2   = mul_q60(x, x);
    term = want_sin ? x : (64'd1 << 60);
    sum  = term;
    for (int unsigned k = 1; k <= SeriesTerms; k++) begin
      dv   = want_sin ? longint'((2 * k) * (2 * k + 1)) : longint'((2 * k - 1) * (2 * k));
      term = udiv64(mul_q60(term, x2), dv);
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // Cosine of d degrees (0 to 90) with cb fraction bits, rounded half up.
  function automatic longint unsigned cos_fix(input int unsigned d, input int unsigned cb);
    longint unsigned v;
    if (d <= 45) v = trig_q60(d, 1'b0);
    else v = trig_q60(90 - d, 1'b1);
    return (v + (64'd1 << (59 - cb))) >> (60 - cb);
  endfunction

endpackage

// File: rtl/mdm_cmd_if.sv
// ----------------------------------------------------------------------------
// Mixer command channel
// Valid/ready channel carrying one drive command word.
// ----------------------------------------------------------------------------
interface mdm_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic        [mdm_pkg::HeadingW-1:0]  heading_deg;
  logic signed [mdm_pkg::CmdW-1:0]      speed;
  logic signed [mdm_pkg::CmdW-1:0]      rotation;

  modport source (output valid, heading_deg, speed, rotation, input ready);
  modport sink (input valid, heading_deg, speed, rotation, output ready);
endinterface

// File: rtl/mdm_power_if.sv
// ----------------------------------------------------------------------------
// Mixer power channel
// Valid/ready channel carrying one word of four wheel powers.
// ----------------------------------------------------------------------------
interface mdm_power_if;
  logic                               valid;
  logic                               ready;
  logic signed [mdm_pkg::PowerW-1:0]  power_front_left;
  logic signed [mdm_pkg::PowerW-1:0]  power_back_left;
  logic signed [mdm_pkg::PowerW-1:0]  power_front_right;
  logic signed [mdm_pkg::PowerW-1:0]  power_back_right;
  logic                               all_zero;

  modport source (output valid, power_front_left, power_back_left, power_front_right,
                  power_back_right, all_zero, input ready);
  modport sink (input valid, power_front_left, power_back_left, power_front_right,
                power_back_right, all_zero, output ready);
endinterface

// File: rtl/mdm_front.sv
// ----------------------------------------------------------------------------
// Mixer front end
// Three stages: heading folding, cosine lookup with speed products, and the
// unscaled wheel terms.
// ----------------------------------------------------------------------------
module mdm_front #(
  parameter int unsigned COS_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic        [mdm_pkg::HeadingW-1:0] heading_deg_i,
  input  logic signed [mdm_pkg::CmdW-1:0]     speed_i,
  input  logic signed [mdm_pkg::CmdW-1:0]     rotation_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COS_BITS+17:0]         u_o [mdm_pkg::NumWheels]
);

  localparam int unsigned W = COS_BITS + 18;

  // Folds an angle to 0..90 degrees; the top bit flags a negative cosine.
  function automatic logic [7:0] fold(input logic [8:0] x);
    logic [8:0] y;
    logic       n;
    y = x;
    n = 1'b0;
    if (y > 9'd180) y = 9'd360 - y;
    if (y > 9'd90) begin
      y = 9'd180 - y;
      n = 1'b1;
    end
    return {n, y[6:0]};
  endfunction

  // Cosine magnitudes for 0..90 degrees.
  logic [COS_BITS:0] cos_tab [91];
  for (genvar g = 0; g < 91; g++) begin : g_tab
    assign cos_tab[g] = (COS_BITS + 1)'(mdm_pkg::cos_fix(g, COS_BITS));
  end

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  // A stage takes a new word when it is empty or its word moves on.
  assign adv3        = !v3_q || out_ready_i;
  assign adv2        = !v2_q || adv3;
  assign adv1        = !v1_q || adv2;
  assign in_ready_o  = adv1;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Stage 1: reduce the heading and fold both cosine angles.
  logic [8:0] h, ta, tb;
  logic [7:0] fa_d, fb_d;
  logic [7:0] fa_q, fb_q;
  logic signed [15:0] spd1_q, rot1_q;

  always_comb begin
    h    = (heading_deg_i >= 9'd360) ? heading_deg_i - 9'd360 : heading_deg_i;
    ta   = 9'd405 - h;
    if (ta >= 9'd360) ta = ta - 9'd360;
    tb   = h + 9'd45;
    if (tb >= 9'd360) tb = tb - 9'd360;
    fa_d = fold(ta);
    fb_d = fold(tb);
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      fa_q   <= fa_d;
      fb_q   <= fb_d;
      spd1_q <= speed_i;
      rot1_q <= rotation_i;
    end
  end

  // Stage 2: look up both cosines and multiply by the speed.
  logic signed [W-1:0] spd_x, ca_x, cb_x;
  logic signed [W-1:0] pa_q, pb_q;
  logic                na_q, nb_q;
  logic signed [15:0]  rot2_q;

  assign spd_x = $signed({{(W - 16){spd1_q[15]}}, spd1_q});
  assign ca_x  = $signed({{(W - COS_BITS - 1){1'b0}}, cos_tab[fa_q[6:0]]});
  assign cb_x  = $signed({{(W - COS_BITS - 1){1'b0}}, cos_tab[fb_q[6:0]]});

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      pa_q   <= spd_x * ca_x;
      pb_q   <= spd_x * cb_x;
      na_q   <= fa_q[7];
      nb_q   <= fb_q[7];
      rot2_q <= rot1_q;
    end
  end

  // Stage 3: apply the cosine signs and add or subtract the rotation.
  logic signed [W-1:0] sa, sb, rx;
  logic signed [W-1:0] u_q [mdm_pkg::NumWheels];

  assign sa = na_q ? -pa_q : pa_q;
  assign sb = nb_q ? -pb_q : pb_q;
  assign rx = $signed({{(W - 16 - COS_BITS){rot2_q[15]}}, rot2_q, {COS_BITS{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      u_q[mdm_pkg::WheelFl] <= sa + rx;
      u_q[mdm_pkg::WheelBl] <= sb + rx;
      u_q[mdm_pkg::WheelFr] <= sb - rx;
      u_q[mdm_pkg::WheelBr] <= sa - rx;
    end
  end

  assign u_o = u_q;

endmodule

// File: rtl/mdm_scale.sv
// ----------------------------------------------------------------------------
// Mixer scaling front
// Two stages: magnitudes with their maximum, then the rounded-division
// numerators and shared denominator.
// ----------------------------------------------------------------------------
module mdm_scale #(
  parameter int unsigned COS_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COS_BITS+17:0]          u_i [mdm_pkg::NumWheels],
  input  logic        [mdm_pkg::MaxPowerW-1:0] max_power_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [COS_BITS+25:0]          num_o [mdm_pkg::NumWheels],
  output logic        [COS_BITS+17:0]          den_o,
  output logic        [mdm_pkg::NumWheels-1:0] neg_o,
  output logic                                 zero_o
);

  localparam int unsigned MW = COS_BITS + 17;
  localparam int unsigned NW = COS_BITS + 26;

  logic v4_q, v5_q, adv4, adv5;

  assign adv5        = !v5_q || out_ready_i;
  assign adv4        = !v4_q || adv5;
  assign in_ready_o  = adv4;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv4) v4_q <= in_valid_i;
      if (adv5) v5_q <= v4_q;
    end
  end

  // Stage 4: magnitudes, signs and the largest magnitude.
  logic [MW-1:0] mag_d [mdm_pkg::NumWheels];
  logic [MW-1:0] mag_q [mdm_pkg::NumWheels];
  logic [MW-1:0] m01, m23, m_d, m_q;
  logic [mdm_pkg::NumWheels-1:0] sg_d, sg_q;

  always_comb begin
    for (int l = 0; l < mdm_pkg::NumWheels; l++) begin
      sg_d[l]  = u_i[l][MW];
      mag_d[l] = sg_d[l] ? MW'(-u_i[l]) : MW'(u_i[l]);
    end
    m01 = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
    m23 = (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
    m_d = (m01 > m23) ? m01 : m23;
  end

  always_ff @(posedge clk_i) begin
    if (adv4 && in_valid_i) begin
      mag_q <= mag_d;
      sg_q  <= sg_d;
      m_q   <= m_d;
    end
  end

  // Stage 5: numerator 2*|u|*max_power + M over denominator 2*M.
  logic [NW-1:0] num_q [mdm_pkg::NumWheels];
  logic [MW:0]   den_q;
  logic [mdm_pkg::NumWheels-1:0] neg_q;
  logic          zero_q;

  always_ff @(posedge clk_i) begin
    if (adv5 && v4_q) begin
      for (int l = 0; l < mdm_pkg::NumWheels; l++) begin
        num_q[l] <= NW'({NW'(mag_q[l]) * NW'(max_power_i), 1'b0}) + NW'(m_q);
      end
      den_q  <= {m_q, 1'b0};
      neg_q  <= sg_q;
      zero_q <= (m_q == '0);
    end
  end

  assign num_o  = num_q;
  assign den_o  = den_q;
  assign neg_o  = neg_q;
  assign zero_o = zero_q;

endmodule

// File: rtl/mdm_divide.sv
// ----------------------------------------------------------------------------
// Mixer divider
// Restoring divider, one quotient bit per stage over four lanes, followed by
// the sign-restoring output register.
// ----------------------------------------------------------------------------
module mdm_divide #(
  parameter int unsigned COS_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [COS_BITS+25:0]          num_i [mdm_pkg::NumWheels],
  input  logic        [COS_BITS+17:0]          den_i,
  input  logic        [mdm_pkg::NumWheels-1:0] neg_i,
  input  logic                                 zero_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mdm_pkg::PowerW-1:0]    power_o [mdm_pkg::NumWheels],
  output logic                                 all_zero_o
);

  localparam int unsigned NW = COS_BITS + 26;
  localparam int unsigned DW = COS_BITS + 18;
  localparam int unsigned QW = mdm_pkg::QuotW;

  logic [QW-1:0] v_q;
  logic          ov_q;
  logic [QW:0]   adv;

  // Ready chain from the output register back to the first stage.
  always_comb begin
    adv[QW] = !ov_q || out_ready_i;
    for (int j = QW - 1; j >= 0; j--) begin
      adv[j] = !v_q[j] || adv[j+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int j = 1; j < QW; j++) begin
        if (adv[j]) v_q[j] <= v_q[j-1];
      end
      if (adv[QW]) ov_q <= v_q[QW-1];
    end
  end

  logic [NW-1:0] rem_q [QW][mdm_pkg::NumWheels];
  logic [QW-1:0] quo_q [QW][mdm_pkg::NumWheels];
  logic [DW-1:0] den_q [QW];
  logic [mdm_pkg::NumWheels-1:0] neg_q [QW];
  logic          zero_q [QW];

  // Each stage compares against the divisor shifted to its quotient bit.
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [NW-1:0] rin [mdm_pkg::NumWheels];
    logic [QW-1:0] qin [mdm_pkg::NumWheels];
    logic [DW-1:0] din;
    logic [mdm_pkg::NumWheels-1:0] nin;
    logic          zin, vin;
    logic [NW-1:0] dsh;

    if (j == 0) begin : g_first
      assign rin = num_i;
      for (genvar l = 0; l < mdm_pkg::NumWheels; l++) begin : g_q0
        assign qin[l] = '0;
      end
      assign din = den_i;
      assign nin = neg_i;
      assign zin = zero_i;
      assign vin = in_valid_i;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign qin = quo_q[j-1];
      assign din = den_q[j-1];
      assign nin = neg_q[j-1];
      assign zin = zero_q[j-1];
      assign vin = v_q[j-1];
    end

    assign dsh = NW'(din) << (QW - 1 - j);

    always_ff @(posedge clk_i) begin
      if (adv[j] && vin) begin
        for (int l = 0; l < mdm_pkg::NumWheels; l++) begin
          if (rin[l] >= dsh) begin
            rem_q[j][l] <= rin[l] - dsh;
            quo_q[j][l] <= {qin[l][QW-2:0], 1'b1};
          end else begin
            rem_q[j][l] <= rin[l];
            quo_q[j][l] <= {qin[l][QW-2:0], 1'b0};
          end
        end
        den_q[j]  <= din;
        neg_q[j]  <= nin;
        zero_q[j] <= zin;
      end
    end
  end

  // Output register: restore signs, force zeros when every term was zero.
  logic signed [mdm_pkg::PowerW-1:0] pw_q [mdm_pkg::NumWheels];
  logic                              az_q;

  always_ff @(posedge clk_i) begin
    if (adv[QW] && v_q[QW-1]) begin
      for (int l = 0; l < mdm_pkg::NumWheels; l++) begin
        if (zero_q[QW-1]) pw_q[l] <= '0;
        else if (neg_q[QW-1][l]) pw_q[l] <= -$signed({1'b0, quo_q[QW-1][l]});
        else pw_q[l] <= $signed({1'b0, quo_q[QW-1][l]});
      end
      az_q <= zero_q[QW-1];
    end
  end

  assign power_o    = pw_q;
  assign all_zero_o = az_q;

endmodule

// File: rtl/mecanum_drive_mixer.sv
// ----------------------------------------------------------------------------
// Mecanum drive mixer
// Turns a heading, speed and rotation command into four scaled wheel powers.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the cmd channel (heading in degrees, speed and rotation
//   in signed Q1.15); each accepted word yields exactly one word on the power
//   channel: four wheel powers scaled so the largest magnitude equals
//   max_power, rounded to nearest with ties away from zero, plus all_zero
//   when every unscaled term was zero (powers are then forced to zero).
//   max_power is written through cfg_we_i / cfg_wdata_i; the user writes it only
//   while the block is idle, which the block does not enforce; it resets to 100.
//   The power word passes 13 register stages between the cmd and power
//   channels: 3 front stages, 2 scaling stages, 7 divider
//   stages (one quotient bit each) and the output register. A new command is
//   taken every cycle while the power channel does not stall.
//   Reset clears all stage valid bits, so nothing is in flight afterwards.
//   When the receiver stalls, words pile up in the empty stages; cmd.ready
//   drops only when all 13 stages hold a word.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer #(
  parameter int unsigned COS_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mdm_cmd_if.sink                             cmd,
  mdm_power_if.source                         power,
  input  logic                                cfg_we_i,
  input  logic [mdm_pkg::MaxPowerW-1:0]       cfg_wdata_i
);

  localparam int unsigned W  = COS_BITS + 18;
  localparam int unsigned NW = COS_BITS + 26;

  // Maximum power register.
  logic [mdm_pkg::MaxPowerW-1:0] max_power_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q <= mdm_pkg::MaxPowerReset;
    end else if (cfg_we_i) begin
      max_power_q <= cfg_wdata_i;
    end
  end

  logic                  f_valid, f_ready;
  logic signed [W-1:0]   u [mdm_pkg::NumWheels];
  logic                  s_valid, s_ready;
  logic [NW-1:0]         num [mdm_pkg::NumWheels];
  logic [W-1:0]          den;
  logic [mdm_pkg::NumWheels-1:0] neg;
  logic                  zero;
  logic signed [mdm_pkg::PowerW-1:0] pw [mdm_pkg::NumWheels];

  // Heading folding, cosine products and wheel terms.
  mdm_front #(.COS_BITS(COS_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (cmd.valid),
    .in_ready_o    (cmd.ready),
    .heading_deg_i (cmd.heading_deg),
    .speed_i       (cmd.speed),
    .rotation_i    (cmd.rotation),
    .out_valid_o   (f_valid),
    .out_ready_i   (f_ready),
    .u_o           (u)
  );

  // Magnitudes, maximum and division operands.
  mdm_scale #(.COS_BITS(COS_BITS)) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .u_i         (u),
    .max_power_i (max_power_q),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .num_o       (num),
    .den_o       (den),
    .neg_o       (neg),
    .zero_o      (zero)
  );

  // Rounded division and output register.
  mdm_divide #(.COS_BITS(COS_BITS)) u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .num_i       (num),
    .den_i       (den),
    .neg_i       (neg),
    .zero_i      (zero),
    .out_valid_o (power.valid),
    .out_ready_i (power.ready),
    .power_o     (pw),
    .all_zero_o  (power.all_zero)
  );

  assign power.power_front_left  = pw[mdm_pkg::WheelFl];
  assign power.power_back_left   = pw[mdm_pkg::WheelBl];
  assign power.power_front_right = pw[mdm_pkg::WheelFr];
  assign power.power_back_right  = pw[mdm_pkg::WheelBr];

endmodule

// File: rtl/mdm_checker.sv
// ----------------------------------------------------------------------------
// Mixer port checker
// Watches the mixer's ports for output hold, zero flag, range and
// back-pressure behavior.
// ----------------------------------------------------------------------------
module mdm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [mdm_pkg::PowerW-1:0] fl_i,
  input logic signed [mdm_pkg::PowerW-1:0] bl_i,
  input logic signed [mdm_pkg::PowerW-1:0] fr_i,
  input logic signed [mdm_pkg::PowerW-1:0] br_i,
  input logic                              all_zero_i
);

  // A stalled power word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fl_i) && $stable(bl_i) &&
    $stable(fr_i) && $stable(br_i) && $stable(all_zero_i))
    else $error("power word changed while stalled");

  // The zero flag always comes with four zero powers.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && all_zero_i |-> fl_i == 0 && bl_i == 0 && fr_i == 0 && br_i == 0)
    else $error("all_zero set with nonzero power");

  // Powers never reach the most negative code.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> fl_i != -128 && bl_i != -128 && fr_i != -128 && br_i != -128)
    else $error("power out of range");

  // Commands are refused only while a finished word is held back.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("command refused without output stall");

endmodule

bind mecanum_drive_mixer mdm_checker u_mdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (cmd.ready),
  .out_valid_i (power.valid),
  .out_ready_i (power.ready),
  .fl_i        (power.power_front_left),
  .bl_i        (power.power_back_left),
  .fr_i        (power.power_front_right),
  .br_i        (power.power_back_right),
  .all_zero_i  (power.all_zero)
);
